// ===== sv/phc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package phc_pkg;

  // Segment types and flag words of the allow table
  localparam logic [31:0] PT_PHDR       = 32'h0000_0006;
  localparam logic [31:0] PT_LOAD       = 32'h0000_0001;
  localparam logic [31:0] PT_UNWIND     = 32'h7000_0001;
  localparam logic [31:0] PT_STACK_MARK = 32'h6474_e551;
  localparam logic [31:0] FLG_R         = 32'h0000_0004;
  localparam logic [31:0] FLG_RX        = 32'h0000_0005;
  localparam logic [31:0] FLG_RW        = 32'h0000_0006;

  // Allow table
  localparam int unsigned ENTRY_COUNT = 6;
  localparam int unsigned TEXT_ENTRY  = 1;
  localparam int unsigned UNWIND_ENTRY = 4;

  typedef logic [ENTRY_COUNT-1:0] entry_vec_t;

  localparam logic [31:0] TAB_TYPE [ENTRY_COUNT] = '{
    PT_PHDR, PT_LOAD, PT_LOAD, PT_LOAD, PT_UNWIND, PT_STACK_MARK
  };
  localparam logic [31:0] TAB_FLAGS [ENTRY_COUNT] = '{
    FLG_R, FLG_RX, FLG_R, FLG_RW, FLG_R, FLG_RW
  };
  // Entries that only get marked as seen (PHDR, unwind)
  localparam entry_vec_t TAB_IGNORE = 6'b01_0001;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_ADDRESS_BITS = 2'd1,
    REG_UNWIND_ENABLE = 2'd2
  } reg_idx_t;

  // Reset values
  localparam logic [31:0] BASE_RESET  = 32'h0002_0000;
  localparam logic [5:0]  ABITS_RESET = 6'd30;
  localparam logic [5:0]  ABITS_NO_LIMIT = 6'd32;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DUP          = 3'd1,
    ST_BAD_LOC      = 3'd2,
    ST_OUTSIDE      = 3'd3,
    ST_BAD_SIZE     = 3'd4,
    ST_EMPTY_TEXT   = 3'd5,
    ST_UNEXPECTED   = 3'd6,
    ST_TEXT_MISSING = 3'd7
  } status_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic        loadable;
    logic [31:0] text_end;
    logic [31:0] highest_end;
    logic        is_report;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/phc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Program header channel
interface phc_hdr_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] seg_type;
  logic [31:0] seg_flags;
  logic [31:0] seg_vaddr;
  logic [31:0] seg_memsz;
  logic [31:0] seg_filesz;

  modport source (output valid, kind, seg_type, seg_flags, seg_vaddr, seg_memsz,
                  seg_filesz, input ready);
  modport sink (input valid, kind, seg_type, seg_flags, seg_vaddr, seg_memsz,
                seg_filesz, output ready);
endinterface

// Result channel
interface phc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        loadable;
  logic [31:0] text_end;
  logic [31:0] highest_end;
  logic        is_report;

  modport source (output valid, status, loadable, text_end, highest_end, is_report,
                  input ready);
  modport sink (input valid, status, loadable, text_end, highest_end, is_report,
                output ready);
endinterface

`default_nettype wire

// ===== sv/program_header_policy_checker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Program header policy checker. Takes one item per cycle on hdr while res is
// not stalled: either a 32-bit ELF program header (kind 0) or a finish marker
// (kind 1), and gives exactly one result on res for each, in order. Each header
// is matched on its type and whole flags word against a six-entry allow table
// and checked in the same cycle it is transferred; the result is registered in
// the output register, or in a skid register behind it while a result is
// stalled, which lets one more item be taken then; hdr.ready drops only when
// both are full. The first error is sticky until a finish item, which reports
// the list status, the text end and the highest segment end and then clears
// the list state. Configuration is written through wr_en/wr_index/wr_data; the
// user must write it only while idle, which the block itself does not enforce.
module program_header_policy_checker_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            wr_en,
  input  wire [phc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire [31:0]                     wr_data,
  phc_hdr_if.sink                        hdr,
  phc_res_if.source                      res
);
  import phc_pkg::*;

  // Configuration registers
  logic [31:0] base_address;
  logic [5:0]  address_bits;
  logic        unwind_entry_enable;

  // List state
  entry_vec_t  seen_entries, seen_entries_next;
  logic [31:0] running_highest_end, running_highest_end_next;
  logic [31:0] running_text_end, running_text_end_next;
  status_t     first_error, first_error_next;

  // Output register and skid register
  res_t        out_data, skid_data, res_next;
  logic        out_valid, skid_valid;

  logic        accept, pop;

  assign hdr.ready = !skid_valid;
  assign accept    = hdr.valid && hdr.ready;
  assign pop       = out_valid && res.ready;

  // Table match
  entry_vec_t  match;
  logic        hit;
  logic        is_text;
  logic        ignored;
  logic [32:0] seg_end;
  logic [31:0] lim_mask;
  status_t     check_status;
  logic        check_load;

  always_comb begin
    for (int j = 0; j < ENTRY_COUNT; j++) begin
      match[j] = (hdr.seg_type == TAB_TYPE[j]) && (hdr.seg_flags == TAB_FLAGS[j]);
    end
    match[UNWIND_ENTRY] = match[UNWIND_ENTRY] && unwind_entry_enable;
  end

  assign hit      = |match;
  assign is_text  = match[TEXT_ENTRY];
  assign ignored  = |(match & TAB_IGNORE);
  assign seg_end  = {1'b0, hdr.seg_vaddr} + {1'b0, hdr.seg_memsz};
  assign lim_mask = (address_bits >= ABITS_NO_LIMIT) ? '0 : ('1 << address_bits[4:0]);

  // Header check and state update
  always_comb begin
    seen_entries_next        = seen_entries;
    running_highest_end_next = running_highest_end;
    running_text_end_next    = running_text_end;
    first_error_next         = first_error;
    check_status             = ST_OK;
    check_load               = 1'b0;
    res_next                 = '0;

    if (hdr.kind) begin
      // Finish: report and clear
      if (first_error != ST_OK) begin
        res_next.status = first_error;
      end else if (!seen_entries[TEXT_ENTRY]) begin
        res_next.status = ST_TEXT_MISSING;
      end else begin
        res_next.status = ST_OK;
      end
      res_next.text_end        = running_text_end;
      res_next.highest_end     = running_highest_end;
      res_next.is_report       = 1'b1;
      seen_entries_next        = '0;
      running_highest_end_next = base_address;
      running_text_end_next    = '0;
      first_error_next         = ST_OK;
    end else if (first_error != ST_OK) begin
      res_next.status = first_error;
    end else begin
      if (!hit) begin
        check_status = (hdr.seg_memsz == '0) ? ST_OK : ST_UNEXPECTED;
      end else if ((seen_entries & match) != '0) begin
        check_status = ST_DUP;
      end else begin
        seen_entries_next = seen_entries | match;
        if (!ignored) begin
          if (hdr.seg_memsz != '0) begin
            if (is_text && (hdr.seg_vaddr != base_address)) begin
              check_status = ST_BAD_LOC;
            end else if (hdr.seg_vaddr < base_address) begin
              check_status = ST_OUTSIDE;
            end else if (seg_end[32]) begin
              check_status = ST_OUTSIDE;
            end else if ((seg_end[31:0] & lim_mask) != '0) begin
              check_status = ST_OUTSIDE;
            end else if (hdr.seg_filesz > hdr.seg_memsz) begin
              check_status = ST_BAD_SIZE;
            end else begin
              check_load = 1'b1;
              if (running_highest_end < seg_end[31:0]) begin
                running_highest_end_next = seg_end[31:0];
              end
              if (is_text) begin
                running_text_end_next = base_address + hdr.seg_filesz;
              end
            end
          end else if (is_text) begin
            check_status = ST_EMPTY_TEXT;
          end
        end
      end
      res_next.status   = check_status;
      res_next.loadable = check_load && (check_status == ST_OK);
      if (check_status != ST_OK) begin
        first_error_next = check_status;
      end
    end
  end

  // Configuration and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address        <= BASE_RESET;
      address_bits        <= ABITS_RESET;
      unwind_entry_enable <= 1'b0;
      seen_entries        <= '0;
      running_highest_end <= BASE_RESET;
      running_text_end    <= '0;
      first_error         <= ST_OK;
    end else if (accept) begin
      seen_entries        <= seen_entries_next;
      running_highest_end <= running_highest_end_next;
      running_text_end    <= running_text_end_next;
      first_error         <= first_error_next;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BASE_ADDRESS: begin
          base_address <= wr_data;
          if (seen_entries == '0) begin
            running_highest_end <= wr_data;
          end
        end
        REG_ADDRESS_BITS:  address_bits        <= wr_data[5:0];
        REG_UNWIND_ENABLE: unwind_entry_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : res_next;
    end else if (accept) begin
      skid_data <= res_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_data.status;
  assign res.loadable    = out_data.loadable;
  assign res.text_end    = out_data.text_end;
  assign res.highest_end = out_data.highest_end;
  assign res.is_report   = out_data.is_report;

  // Skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A finish transfer clears the seen entries
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && hdr.kind) |=> (seen_entries == '0 && first_error == ST_OK))
    else $error("list state not cleared after finish");

  // First error holds until a finish transfer
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_error != ST_OK && !(accept && hdr.kind)) |=> first_error == $past(first_error))
    else $error("sticky error changed without finish");

  // A loadable result always carries ok status and is never a report
  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.loadable) |-> (out_data.status == ST_OK && !out_data.is_report))
    else $error("loadable result with error status or on report");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import phc_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 180;
  localparam int PRINT_CAP     = 40;

  // One item on the header channel
  typedef struct packed {
    logic        kind;
    logic [31:0] seg_type;
    logic [31:0] seg_flags;
    logic [31:0] seg_vaddr;
    logic [31:0] seg_memsz;
    logic [31:0] seg_filesz;
  } hdr_item_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [31:0]          wr_data  = '0;

  phc_hdr_if hdr_ch ();
  phc_res_if res_ch ();

  program_header_policy_checker_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .hdr      (hdr_ch),
    .res      (res_ch)
  );

  always #5 clk = ~clk;

  // Policy state mirrored by the scoreboard
  logic [31:0] cfg_base   = BASE_RESET;
  logic [5:0]  cfg_abits  = ABITS_RESET;
  logic        cfg_unwind = 1'b0;
  entry_vec_t  seen_mask  = '0;
  logic [31:0] high_end_q = BASE_RESET;
  logic [31:0] text_end_q = '0;
  status_t     list_err   = ST_OK;

  hdr_item_t pending_hdrs[$];
  res_t      expected_results[$];

  int       fail_count      = 0;
  int       results_checked = 0;
  int       reports_checked = 0;
  int       loads_checked   = 0;
  int       queued_items    = 0;
  bit [7:0] status_hit      = '0;

  // Driver burst shaping
  int burst_left = 1;
  int gap_left   = 0;

  // Receiver stall pattern
  logic [15:0] stall_pat = 16'hFFFF;
  int          stall_age = 0;

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Expected result of one transferred item; updates the list state
  function automatic res_t predict_result(hdr_item_t it);
    res_t        r;
    int          hit;
    logic [32:0] seg_end;
    status_t     st;
    logic        ld;
    r   = '0;
    st  = ST_OK;
    ld  = 1'b0;
    hit = -1;
    if (it.kind) begin
      // finish: report and clear the list
      if (list_err != ST_OK) st = list_err;
      else if (!seen_mask[TEXT_ENTRY]) st = ST_TEXT_MISSING;
      r.text_end    = text_end_q;
      r.highest_end = high_end_q;
      r.is_report   = 1'b1;
      seen_mask  = '0;
      high_end_q = cfg_base;
      text_end_q = '0;
      list_err   = ST_OK;
    end else if (list_err != ST_OK) begin
      st = list_err;
    end else begin
      for (int j = 0; j < ENTRY_COUNT; j++) begin
        if (hit < 0 && (j != UNWIND_ENTRY || cfg_unwind) &&
            it.seg_type == TAB_TYPE[j] && it.seg_flags == TAB_FLAGS[j])
          hit = j;
      end
      if (hit < 0) begin
        st = (it.seg_memsz == '0) ? ST_OK : ST_UNEXPECTED;
      end else if (seen_mask[hit]) begin
        st = ST_DUP;
      end else begin
        seen_mask[hit] = 1'b1;
        if (!TAB_IGNORE[hit]) begin
          if (it.seg_memsz != '0) begin
            seg_end = {1'b0, it.seg_vaddr} + {1'b0, it.seg_memsz};
            if (hit == TEXT_ENTRY && it.seg_vaddr != cfg_base) st = ST_BAD_LOC;
            else if (it.seg_vaddr < cfg_base) st = ST_OUTSIDE;
            else if (seg_end[32]) st = ST_OUTSIDE;
            else if (cfg_abits < ABITS_NO_LIMIT &&
                     {32'd0, seg_end[31:0]} >= (64'd1 << cfg_abits)) st = ST_OUTSIDE;
            else if (it.seg_filesz > it.seg_memsz) st = ST_BAD_SIZE;
            else begin
              ld = 1'b1;
              if (high_end_q < seg_end[31:0]) high_end_q = seg_end[31:0];
            end
          end
          if (st == ST_OK && hit == TEXT_ENTRY) begin
            if (it.seg_memsz == '0) st = ST_EMPTY_TEXT;
            else text_end_q = cfg_base + it.seg_filesz;
          end
        end
      end
      if (st != ST_OK) begin
        list_err = st;
        ld       = 1'b0;
      end
    end
    r.status   = st;
    r.loadable = ld;
    return r;
  endfunction

  function automatic void queue_hdr(hdr_item_t it);
    pending_hdrs.push_back(it);
    queued_items++;
  endfunction

  function automatic hdr_item_t make_hdr(logic [31:0] t, logic [31:0] f, logic [31:0] va,
                                         logic [31:0] ms, logic [31:0] fs);
    hdr_item_t it;
    it.kind       = 1'b0;
    it.seg_type   = t;
    it.seg_flags  = f;
    it.seg_vaddr  = va;
    it.seg_memsz  = ms;
    it.seg_filesz = fs;
    return it;
  endfunction

  // Fully random payload; kind 1 gives a finish item
  function automatic hdr_item_t rand_noise_hdr(logic kind);
    hdr_item_t it;
    it = make_hdr($urandom, $urandom, $urandom, $urandom, $urandom);
    it.kind = kind;
    if (!kind && $urandom_range(3, 0) == 0) it.seg_memsz = '0;
    return it;
  endfunction

  // Header for table entry e, sized to fit the current space, sometimes broken
  function automatic hdr_item_t rand_entry_hdr(int e);
    hdr_item_t       it;
    longint unsigned lim;
    longint unsigned room;
    int unsigned     span;
    lim  = (cfg_abits >= ABITS_NO_LIMIT) ? 64'h1_0000_0000 : (64'd1 << cfg_abits);
    room = (lim > cfg_base) ? lim - cfg_base : 64'd0;
    if (room / 8 > 64'h10_0000) span = 32'h10_0000;
    else if (room / 8 == 0) span = 1;
    else span = 32'(room / 8);
    it = make_hdr(TAB_TYPE[e], TAB_FLAGS[e], cfg_base, 0, 0);
    it.seg_memsz  = $urandom_range(span, 1);
    it.seg_filesz = $urandom_range(it.seg_memsz, 0);
    if (e != TEXT_ENTRY) it.seg_vaddr = cfg_base + $urandom_range(6 * span, 0);
    case ($urandom_range(19, 0))
      0: it.seg_memsz = '0;
      1: it.seg_filesz = it.seg_memsz + $urandom_range(16, 1);
      2: it.seg_vaddr = cfg_base - $urandom_range(256, 1);
      3: it.seg_vaddr = cfg_base + 4 * $urandom_range(64, 1);
      4: begin
        it.seg_vaddr = 32'hFFFF_FFFF - $urandom_range(255, 0);
        it.seg_memsz = $urandom_range(32'h1_0000, 256);
      end
      5: it.seg_memsz = 32'(lim - it.seg_vaddr) - $urandom_range(1, 0);
      6: it.seg_flags = it.seg_flags ^ (32'd1 << $urandom_range(31, 0));
      default: ;
    endcase
    return it;
  endfunction

  // One header list in shuffled table order, with repeats and noise
  function automatic void queue_random_list();
    int order[ENTRY_COUNT];
    int k;
    int tmp;
    for (int j = 0; j < ENTRY_COUNT; j++) order[j] = j;
    for (int j = ENTRY_COUNT - 1; j > 0; j--) begin
      k        = $urandom_range(j, 0);
      tmp      = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (int j = 0; j < ENTRY_COUNT; j++) begin
      if ($urandom_range(9, 0) < 8) queue_hdr(rand_entry_hdr(order[j]));
      if ($urandom_range(19, 0) == 0) queue_hdr(rand_entry_hdr(order[j]));
      if ($urandom_range(9, 0) == 0) queue_hdr(rand_noise_hdr(1'b0));
    end
    if ($urandom_range(9, 0) != 0) queue_hdr(rand_noise_hdr(1'b1));
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_BASE_ADDRESS: begin
        cfg_base = value;
        if (seen_mask == '0) high_end_q = value;
      end
      REG_ADDRESS_BITS:  cfg_abits  = value[5:0];
      REG_UNWIND_ENABLE: cfg_unwind = value[0];
      default: ;
    endcase
  endtask

  // Block is idle once every header is transferred and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_hdrs.size() != 0 || hdr_ch.valid || expected_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Header driver: bursts with random gaps; predicts on each transfer
  always @(posedge clk) begin : drive_hdr
    hdr_item_t it;
    if (rst) begin
      hdr_ch.valid <= 1'b0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        it.kind       = hdr_ch.kind;
        it.seg_type   = hdr_ch.seg_type;
        it.seg_flags  = hdr_ch.seg_flags;
        it.seg_vaddr  = hdr_ch.seg_vaddr;
        it.seg_memsz  = hdr_ch.seg_memsz;
        it.seg_filesz = hdr_ch.seg_filesz;
        expected_results.push_back(predict_result(it));
      end
      if (!hdr_ch.valid || hdr_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          hdr_ch.valid <= 1'b0;
        end else if (pending_hdrs.size() != 0) begin
          it = pending_hdrs.pop_front();
          hdr_ch.valid      <= 1'b1;
          hdr_ch.kind       <= it.kind;
          hdr_ch.seg_type   <= it.seg_type;
          hdr_ch.seg_flags  <= it.seg_flags;
          hdr_ch.seg_vaddr  <= it.seg_vaddr;
          hdr_ch.seg_memsz  <= it.seg_memsz;
          hdr_ch.seg_filesz <= it.seg_filesz;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          hdr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : check_res
    res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result with no header pending, status %0d",
                                   res_ch.status));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          reports_checked += want.is_report;
          loads_checked   += want.loadable;
          status_hit[want.status] = 1'b1;
          if (res_ch.status !== want.status)
            report_failure($sformatf("result %0d: status %0d, want %s", results_checked,
                                     res_ch.status, want.status.name()));
          if (res_ch.loadable !== want.loadable)
            report_failure($sformatf("result %0d: loadable %b, want %b", results_checked,
                                     res_ch.loadable, want.loadable));
          if (res_ch.text_end !== want.text_end)
            report_failure($sformatf("result %0d: text_end %h, want %h", results_checked,
                                     res_ch.text_end, want.text_end));
          if (res_ch.highest_end !== want.highest_end)
            report_failure($sformatf("result %0d: highest_end %h, want %h",
                                     results_checked, res_ch.highest_end,
                                     want.highest_end));
          if (res_ch.is_report !== want.is_report)
            report_failure($sformatf("result %0d: is_report %b, want %b", results_checked,
                                     res_ch.is_report, want.is_report));
        end
      end
      // new stall pattern now and then; never all zero
      if (stall_age == 127) begin
        stall_age = 0;
        stall_pat = ($urandom_range(3, 0) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
        stall_age++;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      res_ch.ready <= stall_pat[0];
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // Stimulus: directed lists, then random phases under changing registers
  initial begin : stimulus
    logic [5:0]  abits;
    logic [31:0] base;
    logic        unwind;
    int          phase_start;
    hdr_ch.valid      = 1'b0;
    hdr_ch.kind       = 1'b0;
    hdr_ch.seg_type   = '0;
    hdr_ch.seg_flags  = '0;
    hdr_ch.seg_vaddr  = '0;
    hdr_ch.seg_memsz  = '0;
    hdr_ch.seg_filesz = '0;
    res_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    @(negedge clk);
    // finish on an empty list: text missing
    queue_hdr(rand_noise_hdr(1'b1));
    // clean list, every table role but unwind
    queue_hdr(make_hdr(PT_PHDR, FLG_R, 32'h34, 32'h120, 32'h120));
    queue_hdr(make_hdr(PT_LOAD, FLG_RX, BASE_RESET, 32'h1000, 32'h800));
    queue_hdr(make_hdr(PT_LOAD, FLG_R, BASE_RESET + 32'h1000, 32'h400, 32'h400));
    queue_hdr(make_hdr(PT_LOAD, FLG_RW, BASE_RESET + 32'h2000, 32'h1000, 32'h10));
    queue_hdr(make_hdr(PT_STACK_MARK, FLG_RW, 32'h0, 32'h0, 32'h0));
    queue_hdr(rand_noise_hdr(1'b1));
    // unmatched of zero size is fine; unwind while disabled sticks an error
    queue_hdr(make_hdr('1, '1, '1, 32'h0, '1));
    queue_hdr(make_hdr(PT_UNWIND, FLG_R, BASE_RESET, 32'h8, 32'h8));
    queue_hdr(make_hdr(PT_LOAD, FLG_RX, BASE_RESET, 32'h100, 32'h100));
    queue_hdr(rand_noise_hdr(1'b1));
    // duplicate entry
    queue_hdr(make_hdr(PT_PHDR, FLG_R, 32'h34, 32'h0, 32'h0));
    queue_hdr(make_hdr(PT_PHDR, FLG_R, 32'h34, 32'h0, 32'h0));
    queue_hdr(rand_noise_hdr(1'b1));
    // text away from base
    queue_hdr(make_hdr(PT_LOAD, FLG_RX, BASE_RESET + 32'h4, 32'h100, 32'h10));
    queue_hdr(rand_noise_hdr(1'b1));
    // below base
    queue_hdr(make_hdr(PT_LOAD, FLG_R, BASE_RESET - 32'h10, 32'h10, 32'h10));
    queue_hdr(rand_noise_hdr(1'b1));
    // end wraps past the top of the space
    queue_hdr(make_hdr(PT_LOAD, FLG_RW, 32'hFFFF_F000, 32'h2000, 32'h0));
    queue_hdr(rand_noise_hdr(1'b1));
    // end exactly at the address-bit limit
    queue_hdr(make_hdr(PT_LOAD, FLG_R, 32'h3FFF_F000, 32'h1000, 32'h0));
    queue_hdr(rand_noise_hdr(1'b1));
    // file size above memory size
    queue_hdr(make_hdr(PT_LOAD, FLG_RX, BASE_RESET, 32'h100, 32'h101));
    queue_hdr(rand_noise_hdr(1'b1));
    // empty text
    queue_hdr(make_hdr(PT_LOAD, FLG_RX, BASE_RESET, 32'h0, 32'h0));
    queue_hdr(rand_noise_hdr(1'b1));
    wait_drained();

    // random phases: low extremes, high extremes, then random settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        abits  = 6'd12;
        base   = 32'h0;
        unwind = 1'b1;
      end else if (p == 1) begin
        abits  = ABITS_NO_LIMIT;
        base   = 32'hFFFF_FFFF;
        unwind = 1'b0;
      end else begin
        abits  = 6'($urandom_range(32, 12));
        base   = $urandom_range(32'(64'd1 << (abits - 6'd1)), 0);
        unwind = 1'($urandom_range(1, 0));
      end
      write_reg(REG_ADDRESS_BITS, {26'd0, abits});
      write_reg(REG_BASE_ADDRESS, base);
      write_reg(REG_UNWIND_ENABLE, {31'd0, unwind});
      @(negedge clk);
      phase_start = queued_items;
      while (queued_items - phase_start < PHASE_ITEMS) queue_random_list();
      wait_drained();
    end

    repeat (5) @(posedge clk);
    $display("checked %0d results: %0d list reports, %0d loadable segments",
             results_checked, reports_checked, loads_checked);
    $display("%0d of 8 status codes seen over %0d register settings",
             $countones(status_hit), RANDOM_PHASES + 1);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
